// File: sv/kwm_pkg.sv
`timescale 1ns / 1ps
// kwm_pkg: types, constants and the head-compare helper for the k-way merge.
// No dependencies; imported by k_way_sorted_merge and tb_k_way_sorted_merge.
package kwm_pkg;

  localparam int unsigned DEF_MAX_ROWS = 8;  // default row count, range 1..8
  localparam int unsigned TREE_LEAVES  = 8;  // compare tree is built for up to 8 rows
  localparam int unsigned TREE_RW      = 3;  // row index width inside the tree
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned COL_W        = 4;
  localparam int unsigned CFG_W        = 4;

  typedef logic signed [VAL_W-1:0] val_t;

  // one candidate head in the min tree
  typedef struct packed {
    logic               vld;
    logic [TREE_RW-1:0] row;
    val_t               val;
  } cand_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INIT_RD = 6'b000010,
    S_INIT_WR = 6'b000100,
    S_PAIR    = 6'b001000,
    S_PICK    = 6'b010000,
    S_FETCH   = 6'b100000
  } state_t;

  // smaller of two heads; a is the lower row and wins ties
  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    cand_t res;
    if (b.vld && (!a.vld || (b.val < a.val))) res = b;
    else res = a;
    return res;
  endfunction

endpackage

// File: sv/k_way_sorted_merge.sv
`timescale 1ns / 1ps
// k_way_sorted_merge: loads a k-by-k matrix one element per cycle, then emits
// its k*k values in merged order (min over row heads, ties to the lower row).
// After the last element, the row heads are primed row by row (store read,
// head write), then each result passes pair compare, final pick and store
// read, and head refill; busy is high throughout. Loading takes one element
// per cycle while busy is low. Reset clears control state and sets k
// to 8; the element store is not cleared. Results are strobed, never stalled.
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_order_size,
  // input transactions
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] in_element_value,
  // result transactions
  output logic             out_strobe,
  output logic [VAL_W-1:0] out_merged_value,
  output logic             out_is_final
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LCW   = $clog2(DEPTH + 1);
  localparam int unsigned KW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned XW    = 2 * KW + 1;

  // ---------------------------------------------------------------------------
  // registers
  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         order_size_r;
  logic [LCW-1:0]           load_cnt_r, load_cnt_nxt;
  logic [LCW-1:0]           out_cnt_r, out_cnt_nxt;
  logic [TREE_RW-1:0]       init_row_r, init_row_nxt;
  logic [TREE_LEAVES-1:0]   head_vld_r;
  logic [COL_W-1:0]         col_r [TREE_LEAVES];
  val_t                     head_r [TREE_LEAVES];
  cand_t                    pair_r [TREE_LEAVES/2];
  cand_t                    sel_r;
  logic                     out_strobe_r;
  val_t                     out_value_r;
  logic                     out_final_r;

  val_t                     mem [DEPTH];
  val_t                     rd_data_r;

  // ---------------------------------------------------------------------------
  // effective k and element count
  logic [KW-1:0]  k_eff;
  logic [LCW-1:0] total;

  always_comb begin
    if (order_size_r == '0) k_eff = KW'(1);
    else if (order_size_r > CFG_W'(MAX_ROWS)) k_eff = KW'(MAX_ROWS);
    else k_eff = KW'(order_size_r);
  end

  assign total = LCW'(k_eff) * LCW'(k_eff);

  // ---------------------------------------------------------------------------
  // compare tree: leaves are the row head registers
  cand_t leaf [TREE_LEAVES];
  cand_t pair_nxt [TREE_LEAVES/2];
  cand_t half0, half1, best;

  always_comb begin
    for (int j = 0; j < TREE_LEAVES; j++) begin
      leaf[j].vld = head_vld_r[j];
      leaf[j].row = TREE_RW'(j);
      leaf[j].val = head_r[j];
    end
    for (int i = 0; i < TREE_LEAVES/2; i++) begin
      pair_nxt[i] = cand_min(leaf[2*i], leaf[2*i+1]);
    end
    half0 = cand_min(pair_r[0], pair_r[1]);
    half1 = cand_min(pair_r[2], pair_r[3]);
    best  = cand_min(half0, half1);
  end

  // next column of the winning row, and whether that row still has entries
  logic [COL_W-1:0] best_col_inc;
  logic             best_more;
  logic [XW-1:0]    addr_x;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;

  assign best_col_inc = col_r[best.row] + COL_W'(1);
  assign best_more    = best_col_inc < COL_W'(k_eff);

  always_comb begin
    if (state_r == S_INIT_RD) begin
      addr_x = XW'(init_row_r) * XW'(k_eff);
      rd_en  = 1'b1;
    end else begin
      addr_x = XW'(best.row) * XW'(k_eff) + XW'(best_col_inc);
      rd_en  = (state_r == S_PICK) && best_more;
    end
    rd_addr = addr_x[AW-1:0];
  end

  // ---------------------------------------------------------------------------
  // element store
  logic accept;
  logic cfg_wr;
  logic load_done;

  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign load_done = accept && ((load_cnt_r + LCW'(1)) == total);

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[load_cnt_r[AW-1:0]] <= val_t'(in_element_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // control
  logic last_out;
  assign last_out = (out_cnt_r + LCW'(1)) == total;

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    init_row_nxt = init_row_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_wr) begin
          load_cnt_nxt = '0;
        end else if (load_done) begin
          load_cnt_nxt = '0;
          out_cnt_nxt  = '0;
          init_row_nxt = '0;
          state_nxt    = S_INIT_RD;
        end else if (accept) begin
          load_cnt_nxt = load_cnt_r + LCW'(1);
        end
      end
      S_INIT_RD: state_nxt = S_INIT_WR;
      S_INIT_WR: begin
        if (KW'(init_row_r) + KW'(1) == k_eff) begin
          state_nxt = S_PAIR;
        end else begin
          init_row_nxt = init_row_r + TREE_RW'(1);
          state_nxt    = S_INIT_RD;
        end
      end
      S_PAIR: state_nxt = S_PICK;
      S_PICK: begin
        out_cnt_nxt = out_cnt_r + LCW'(1);
        state_nxt   = last_out ? S_IDLE : S_FETCH;
      end
      S_FETCH: state_nxt = S_PAIR;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      order_size_r <= CFG_W'(8);
      load_cnt_r   <= '0;
      out_cnt_r    <= '0;
      init_row_r   <= '0;
      head_vld_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_cnt_r   <= load_cnt_nxt;
      out_cnt_r    <= out_cnt_nxt;
      init_row_r   <= init_row_nxt;
      out_strobe_r <= (state_r == S_PICK);
      if (cfg_wr) begin
        order_size_r <= cfg_order_size;
      end
      if (load_done) begin
        head_vld_r <= '0;
      end else if (state_r == S_INIT_WR) begin
        head_vld_r[init_row_r] <= 1'b1;
      end else if (state_r == S_PICK && !best_more) begin
        head_vld_r[best.row] <= 1'b0;  // row exhausted
      end
    end
  end

  // head values, column pointers and pipeline payload
  always_ff @(posedge clk) begin
    if (state_r == S_INIT_WR) begin
      head_r[init_row_r] <= rd_data_r;
      col_r[init_row_r]  <= '0;
    end
    if (state_r == S_PICK) begin
      col_r[best.row] <= best_col_inc;
      sel_r           <= best;
      out_value_r     <= best.val;
      out_final_r     <= last_out;
    end
    if (state_r == S_FETCH && head_vld_r[sel_r.row]) begin
      head_r[sel_r.row] <= rd_data_r;
    end
    if (state_r == S_PAIR) begin
      for (int i = 0; i < TREE_LEAVES/2; i++) begin
        pair_r[i] <= pair_nxt[i];
      end
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = !busy;
  assign out_strobe       = out_strobe_r;
  assign out_merged_value = out_value_r;
  assign out_is_final     = out_final_r;

  // ---------------------------------------------------------------------------
  // assertions
  a_pick_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> best.vld)
    else $error("merge pick found no live row head");

  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("results issued on consecutive cycles");

  a_final_ends_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_final_r) |-> (!busy && load_cnt_r == '0))
    else $error("final result while merge still running");

  a_cfg_clears_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (load_cnt_r == '0))
    else $error("config write did not abort the partial load");

endmodule

// File: sim/tb_k_way_sorted_merge.sv
`timescale 1ns / 1ps
// tb_k_way_sorted_merge: self-checking testbench for the k-way sorted merge.
// Depends on kwm_pkg and k_way_sorted_merge; predicts each merged sequence
// in-house and compares every strobed result against it.
module tb_k_way_sorted_merge
  import kwm_pkg::*;
();

  localparam int unsigned ITEM_TARGET    = 380;
  localparam int unsigned MAX_GAP        = 12;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 2 * 8 + 3 * 64 + 8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned STORE_DEPTH    = 64;

  typedef enum int unsigned {
    FILL_WIDE,
    FILL_NARROW,
    FILL_SORTED,
    FILL_EXTREME
  } fill_t;

  typedef struct {
    val_t value;
    logic last;
  } merged_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_order_size;
  logic             start;
  logic             busy;
  logic [VAL_W-1:0] in_element_value;
  logic             out_strobe;
  logic [VAL_W-1:0] out_merged_value;
  logic             out_is_final;

  // in-house copy of the block state
  val_t             matrix_store [STORE_DEPTH];
  logic [6:0]       loaded_count;
  logic [CFG_W-1:0] order_reg;
  merged_t          merged_due [$];

  bit          steady_feed;
  int unsigned error_count;
  int unsigned elements_sent;
  int unsigned results_seen;
  int unsigned matrices_done;
  int unsigned cfg_writes;
  int unsigned idle_cycles;

  k_way_sorted_merge dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_order_size   (cfg_order_size),
    .start            (start),
    .busy             (busy),
    .in_element_value (in_element_value),
    .out_strobe       (out_strobe),
    .out_merged_value (out_merged_value),
    .out_is_final     (out_is_final)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned rows_in_use();
    int unsigned k;
    k = order_reg;
    if (k < 1) k = 1;
    if (k > 8) k = 8;
    return k;
  endfunction

  // min over row heads, ties to the lower row; queues the whole sequence
  function automatic void merge_matrix();
    int unsigned k;
    int unsigned total;
    int unsigned head_col [8];
    int unsigned best_row;
    val_t        best_val;
    val_t        v;
    bit          found;
    merged_t     item;
    k = rows_in_use();
    total = k * k;
    foreach (head_col[i]) head_col[i] = 0;
    for (int unsigned n = 0; n < total; n++) begin
      found = 1'b0;
      best_row = 0;
      best_val = '0;
      for (int unsigned r = 0; r < k; r++) begin
        if (head_col[r] < k) begin
          v = matrix_store[(r * k + head_col[r]) % STORE_DEPTH];
          if (!found || v < best_val) begin
            found = 1'b1;
            best_row = r;
            best_val = v;
          end
        end
      end
      head_col[best_row]++;
      item.value = best_val;
      item.last  = (n + 1 == total);
      merged_due = {merged_due, item};
    end
    matrices_done++;
  endfunction

  function automatic void absorb_element(input val_t v);
    int unsigned k;
    k = rows_in_use();
    matrix_store[loaded_count % STORE_DEPTH] = v;
    loaded_count = loaded_count + 7'd1;
    if (loaded_count >= k * k) begin
      merge_matrix();
      loaded_count = '0;
    end
  endfunction

  function automatic val_t extreme_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      4: return 32'sh0000_0001;
      default: return 32'sh8000_0001;
    endcase
  endfunction

  // one transaction; start stays high across back-to-back items
  task automatic send_element(input val_t v);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (busy);
    absorb_element(v);
    elements_sent++;
  endtask

  task automatic wait_drained();
    while (merged_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_order_size(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_order_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // a write drops any partial matrix
    order_reg = v;
    loaded_count = '0;
    cfg_writes++;
  endtask

  task automatic send_matrix(input fill_t fill);
    int unsigned k;
    val_t        run;
    val_t        v;
    k = rows_in_use();
    run = '0;
    for (int unsigned r = 0; r < k; r++) begin
      for (int unsigned c = 0; c < k; c++) begin
        case (fill)
          FILL_NARROW:  v = $signed($urandom_range(0, 6)) - 3;
          FILL_EXTREME: v = extreme_value();
          FILL_SORTED: begin
            if (c == 0) run = $signed($urandom) >>> 3;
            v = run;
            run = run + $signed($urandom_range(0, 1000));
          end
          default:      v = $urandom;
        endcase
        send_element(v);
      end
    end
  endtask

  task automatic test_reset_order();
    // no write yet: k comes from reset
    steady_feed = 1'b1;
    send_matrix(FILL_WIDE);
    steady_feed = 1'b0;
  endtask

  task automatic test_single_row();
    write_order_size(4'd0);  // acts as k = 1
    send_element(32'sh8000_0000);
    send_element(32'sh7fff_ffff);
    write_order_size(4'd1);
    send_element(-32'sd1);
  endtask

  task automatic test_tie_to_lower_row();
    write_order_size(4'd2);
    // lower row must win the tie on 3, giving 3 3 1 9
    send_element(32'sd3);
    send_element(32'sd9);
    send_element(32'sd3);
    send_element(32'sd1);
  endtask

  task automatic test_unsorted_extremes();
    steady_feed = 1'b1;
    send_element(32'sh7fff_ffff);
    send_element(32'sh8000_0000);
    send_element(-32'sd1);
    send_element(32'sd0);
    steady_feed = 1'b0;
  endtask

  task automatic test_abort_partial_load();
    write_order_size(4'd9);  // clamps to 8
    repeat (5) send_element($urandom);
    write_order_size(4'd2);
    repeat (4) send_element($urandom);
  endtask

  task automatic test_random_merges();
    logic [CFG_W-1:0] size;
    int unsigned      k;
    int unsigned      runs;
    while (elements_sent < ITEM_TARGET) begin
      // favor small k so most phases stay short
      size = ($urandom_range(0, 9) < 7) ? CFG_W'($urandom_range(0, 4))
                                         : CFG_W'($urandom_range(5, 15));
      write_order_size(size);
      k = rows_in_use();
      runs = $urandom_range(1, 3);
      for (int unsigned m = 0; m < runs && elements_sent < ITEM_TARGET; m++) begin
        steady_feed = ($urandom_range(0, 3) == 0);
        send_matrix(fill_t'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          wait_drained();
        end
      end
      // broken matrix, cut short by the next size write
      if (k > 1 && $urandom_range(0, 5) == 0) begin
        steady_feed = 1'b0;
        repeat ($urandom_range(1, k * k - 1)) send_element($urandom);
      end
    end
    steady_feed = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    merged_t exp;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (merged_due.size() == 0) begin
        $display("%0t: unexpected result value=%0d final=%b", $time,
                 $signed(out_merged_value), out_is_final);
        error_count++;
      end else begin
        exp = merged_due.pop_front();
        if (out_merged_value !== exp.value) begin
          $display("%0t: merged_value expected %0d actual %0d", $time,
                   exp.value, $signed(out_merged_value));
          error_count++;
        end
        if (out_is_final !== exp.last) begin
          $display("%0t: is_final expected %b actual %b", $time,
                   exp.last, out_is_final);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_order_size <= '0;
    start <= 1'b0;
    in_element_value <= '0;
    order_reg = 4'd8;
    loaded_count = '0;
    steady_feed = 1'b0;
    error_count = 0;
    elements_sent = 0;
    results_seen = 0;
    matrices_done = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_order();
    test_single_row();
    test_tie_to_lower_row();
    test_unsorted_extremes();
    test_abort_partial_load();
    test_random_merges();

    start <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d elements in %0d merged matrices, %0d results checked",
             elements_sent, matrices_done, results_seen);
    $display("%0d order_size writes incl. clamped sizes and aborted partial loads",
             cfg_writes);
    if (error_count == 0 && merged_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (merged_due.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, merged_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
